// ===== src/sdie_pkg.sv =====
// Package: shared constants, request codes, controller/datapath command types.
package sdie_pkg;

    localparam int IMAGE_BYTES_DEF = 18;

    localparam logic [2:0] REQ_BIG     = 3'd0;
    localparam logic [2:0] REQ_SMALL   = 3'd1;
    localparam logic [2:0] REQ_SYMBOL  = 3'd2;
    localparam logic [2:0] REQ_SMILEY  = 3'd3;
    localparam logic [2:0] REQ_BATTERY = 3'd4;
    localparam logic [2:0] REQ_BLE     = 3'd5;

    // Digit position codes
    localparam logic [2:0] POS_HUNDREDS    = 3'd0;
    localparam logic [2:0] POS_TENS        = 3'd1;
    localparam logic [2:0] POS_UNITS       = 3'd2;
    localparam logic [2:0] POS_SMALL_TENS  = 3'd3;
    localparam logic [2:0] POS_SMALL_UNITS = 3'd4;

    typedef struct packed {
        logic       load;      // latch request, apply clears / fixed patterns
        logic       div_step;  // one divide-by-ten iteration
        logic       round;     // finish no-point rounding
        logic       draw;      // draw one digit
        logic [2:0] draw_pos;
        logic [1:0] draw_sel;  // 0 units, 1 tens, 2 hundreds, 3 forced zero
        logic       publish;   // copy image to output register
    } sdie_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       numeric;   // digits need drawing
        logic       point_off; // big number divided by ten
        logic       has_hund;
        logic       has_tens;
    } sdie_stat_t;

    function automatic logic [10:0] digit_mask(input logic [3:0] d);
        case (d)
            4'd0: digit_mask = 11'h3FF;
            4'd1: digit_mask = 11'h00E;
            4'd2: digit_mask = 11'h6F7;
            4'd3: digit_mask = 11'h63F;
            4'd4: digit_mask = 11'h78E;
            4'd5: digit_mask = 11'h7BD;
            4'd6: digit_mask = 11'h7FD;
            4'd7: digit_mask = 11'h20F;
            4'd8: digit_mask = 11'h7FF;
            4'd9: digit_mask = 11'h7BF;
            default: digit_mask = 11'h000;
        endcase
    endfunction

    // Segment location {byte[4:0], bit[2:0]} for position p, segment s (0..10)
    function automatic logic [7:0] seg_loc(input logic [2:0] p, input logic [3:0] s);
        logic [7:0] r;
        r = 8'd0;
        case (p)
            POS_HUNDREDS: case (s)
                4'd0: r = {5'd16, 3'd7}; 4'd1: r = {5'd15, 3'd4}; 4'd2: r = {5'd14, 3'd1};
                4'd3: r = {5'd14, 3'd7}; 4'd4: r = {5'd12, 3'd5}; 4'd5: r = {5'd12, 3'd4};
                4'd6: r = {5'd13, 3'd3}; 4'd7: r = {5'd15, 3'd7}; 4'd8: r = {5'd15, 3'd6};
                4'd9: r = {5'd15, 3'd5}; 4'd10: r = {5'd14, 3'd0}; default: r = 8'd0;
            endcase
            POS_TENS: case (s)
                4'd0: r = {5'd15, 3'd0}; 4'd1: r = {5'd15, 3'd1}; 4'd2: r = {5'd14, 3'd6};
                4'd3: r = {5'd13, 3'd0}; 4'd4: r = {5'd13, 3'd5}; 4'd5: r = {5'd13, 3'd4};
                4'd6: r = {5'd14, 3'd5}; 4'd7: r = {5'd14, 3'd4}; 4'd8: r = {5'd15, 3'd3};
                4'd9: r = {5'd15, 3'd2}; 4'd10: r = {5'd14, 3'd3}; default: r = 8'd0;
            endcase
            POS_UNITS: case (s)
                4'd0: r = {5'd13, 3'd1}; 4'd1: r = {5'd13, 3'd7}; 4'd2: r = {5'd12, 3'd1};
                4'd3: r = {5'd12, 3'd7}; 4'd4: r = {5'd11, 3'd5}; 4'd5: r = {5'd11, 3'd2};
                4'd6: r = {5'd12, 3'd6}; 4'd7: r = {5'd12, 3'd0}; 4'd8: r = {5'd13, 3'd6};
                4'd9: r = {5'd13, 3'd2}; 4'd10: r = {5'd12, 3'd2}; default: r = 8'd0;
            endcase
            POS_SMALL_TENS: case (s)
                4'd0: r = {5'd9, 3'd1}; 4'd1: r = {5'd9, 3'd7}; 4'd2: r = {5'd8, 3'd5};
                4'd3: r = {5'd1, 3'd1}; 4'd4: r = {5'd0, 3'd3}; 4'd5: r = {5'd1, 3'd4};
                4'd6: r = {5'd9, 3'd4}; 4'd7: r = {5'd10, 3'd0}; 4'd8: r = {5'd10, 3'd6};
                4'd9: r = {5'd10, 3'd3}; 4'd10: r = {5'd8, 3'd2}; default: r = 8'd0;
            endcase
            POS_SMALL_UNITS: case (s)
                4'd0: r = {5'd7, 3'd7}; 4'd1: r = {5'd6, 3'd5}; 4'd2: r = {5'd2, 3'd0};
                4'd3: r = {5'd2, 3'd3}; 4'd4: r = {5'd0, 3'd2}; 4'd5: r = {5'd1, 3'd7};
                4'd6: r = {5'd2, 3'd6}; 4'd7: r = {5'd7, 3'd4}; 4'd8: r = {5'd7, 3'd1};
                4'd9: r = {5'd8, 3'd6}; 4'd10: r = {5'd6, 3'd2}; default: r = 8'd0;
            endcase
            default: r = 8'd0;
        endcase
        seg_loc = r;
    endfunction

endpackage

// ===== src/sdie_ctrl.sv =====
// Controller: sequences load, division, rounding, digit drawing and publish.
module sdie_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  sdie_pkg::sdie_stat_t   stat,
    output sdie_pkg::sdie_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_DIV, S_ROUND, S_DRAW, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Draw step list: big numbers 0 units, 1 tens, 2 hundreds; small numbers 0 units, 1 tens
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cnt_next = 3'd0;
                if (!stat.numeric)
                begin
                    state_next = S_OUT;
                end
                else if (stat.point_off)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DRAW;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                cnt_next   = 3'd0;
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (stat.req == sdie_pkg::REQ_BIG)
                begin
                    case (cnt_reg)
                        3'd0:
                        begin
                            cmd.draw     = 1'b1;
                            cmd.draw_pos = sdie_pkg::POS_UNITS;
                            cmd.draw_sel = 2'd0;
                        end
                        3'd1:
                        begin
                            cmd.draw     = 1'b1;
                            cmd.draw_pos = sdie_pkg::POS_TENS;
                            cmd.draw_sel = stat.has_tens ? 2'd1 : 2'd3;
                        end
                        default:
                        begin
                            cmd.draw     = stat.has_hund;
                            cmd.draw_pos = sdie_pkg::POS_HUNDREDS;
                            cmd.draw_sel = 2'd2;
                            state_next   = S_OUT;
                        end
                    endcase
                end
                else
                begin
                    if (cnt_reg == 3'd0)
                    begin
                        cmd.draw     = 1'b1;
                        cmd.draw_pos = sdie_pkg::POS_SMALL_UNITS;
                        cmd.draw_sel = 2'd0;
                    end
                    else
                    begin
                        cmd.draw     = stat.has_tens;
                        cmd.draw_pos = sdie_pkg::POS_SMALL_TENS;
                        cmd.draw_sel = 2'd1;
                        state_next   = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/sdie_dpath.sv =====
// Datapath: image store, magnitude/divide unit, digit painter, output register.
module sdie_dpath
#(
    parameter int IMAGE_BYTES = sdie_pkg::IMAGE_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [2:0]            req_type,
    input  logic signed [15:0]    value,
    input  logic                  percent_on,
    input  sdie_pkg::sdie_cmd_t   cmd,
    output sdie_pkg::sdie_stat_t  stat,
    output logic [63:0]           image_low,
    output logic [63:0]           image_mid,
    output logic [15:0]           image_high
);

    localparam int IMG_W = IMAGE_BYTES * 8;

    logic [IMG_W-1:0] img_reg, img_next;
    logic [2:0]       req_reg;
    logic             numeric_reg, point_off_reg;
    logic [14:0]      mag_reg, mag_next;   // up to 19995
    logic [14:0]      quo_reg;
    logic [14:0]      rem_reg;
    logic [14:0]      rest_reg;            // magnitude left to peel into digits
    logic [143:0]     out_reg;

    logic [14:0] rem_w;
    logic [14:0] quo_w;
    logic [14:0] rest_q;
    logic [3:0]  rest_dig, dsel;
    logic [10:0] msk;
    logic [7:0]  loc;
    logic [IMG_W-1:0] paint;

    // Divide by ten through a reciprocal multiply, exact for every 15-bit input
    function automatic logic [14:0] div10(input logic [14:0] x);
        logic [31:0] p;
        p     = 32'(x) * 32'd52429;
        div10 = {3'b000, p[30:19]};
    endfunction

    // Quotient and remainder of the magnitude by ten
    assign quo_w = div10(mag_reg);
    assign rem_w = mag_reg - ((quo_w << 3) + (quo_w << 1));

    // Peel the next decimal digit off the remaining magnitude
    assign rest_q   = div10(rest_reg);
    assign rest_dig = 4'(rest_reg - ((rest_q << 3) + (rest_q << 1)));

    assign stat.req       = req_reg;
    assign stat.numeric   = numeric_reg;
    assign stat.point_off = point_off_reg;
    assign stat.has_hund  = (mag_reg > 15'd99);
    assign stat.has_tens  = (mag_reg > 15'd9);

    always_comb
    begin
        case (cmd.draw_sel)
            2'd3:    dsel = 4'd0;
            default: dsel = rest_dig;
        endcase
        msk   = sdie_pkg::digit_mask(dsel);
        paint = '0;
        for (int s = 0; s < 11; s++)
        begin
            loc = sdie_pkg::seg_loc(cmd.draw_pos, 4'(s));
            if (msk[s] && (int'(loc[7:3]) < IMAGE_BYTES))
            begin
                paint[int'(loc[7:3]) * 8 + int'(loc[2:0])] = 1'b1;
            end
        end
    end

    // Next image from load, round, draw
    logic signed [15:0] v;
    logic [15:0]        absv;
    logic [7:0]         b16;
    always_comb
    begin
        img_next = img_reg;
        mag_next = mag_reg;
        v        = value;
        absv     = v[15] ? 16'(-v) : 16'(v);
        b16      = img_reg[16*8 +: 8];
        if (cmd.load)
        begin
            case (req_type)
                sdie_pkg::REQ_BIG:
                begin
                    img_next[11*8 +: 8] = 8'h00;
                    img_next[12*8 +: 8] = 8'h00;
                    img_next[13*8 +: 8] = 8'h00;
                    img_next[14*8 +: 8] = img_reg[14*8 +: 8] & 8'h04;
                    img_next[15*8 +: 8] = 8'h00;
                    b16                 = b16 & 8'h70;
                    if (v > 16'sd19995)
                    begin
                        img_next[12*8 +: 8] = 8'h10;
                        img_next[13*8 +: 8] = 8'h09;
                        img_next[14*8 +: 8] = 8'hC3;
                        img_next[15*8 +: 8] = 8'hF0;
                    end
                    else if (v < -16'sd995)
                    begin
                        img_next[12*8 +: 8] = 8'h30;
                        img_next[13*8 +: 8] = 8'h39;
                        img_next[14*8 +: 8] = 8'h38;
                        img_next[15*8 +: 8] = 8'hE0;
                    end
                    else
                    begin
                        if (v[15])
                        begin
                            img_next[14*8 +: 8] = 8'h01;
                        end
                        mag_next = absv[14:0];
                        if (v > 16'sd1995 || v < -16'sd95)
                        begin
                            b16 = b16 & 8'hDF;
                        end
                        else
                        begin
                            b16 = b16 | 8'h20;
                            if (absv > 16'd999)
                            begin
                                img_next[12*8 +: 8] = 8'h08;
                            end
                        end
                    end
                    img_next[16*8 +: 8] = b16;
                end
                sdie_pkg::REQ_SMALL:
                begin
                    img_next[0*8 +: 24] = 24'h0;
                    img_next[6*8 +: 40] = 40'h0;
                    if (percent_on)
                    begin
                        img_next[16*8 + 5] = 1'b1;
                    end
                    if (v > 16'sd99)
                    begin
                        img_next[1*8 +: 8]  = 8'h12;
                        img_next[2*8 +: 8]  = 8'h09;
                        img_next[8*8 +: 8]  = 8'h24;
                        img_next[9*8 +: 8]  = 8'h90;
                        img_next[10*8 +: 8] = 8'h49;
                    end
                    else if (v < -16'sd9)
                    begin
                        img_next[0*8 +: 8]  = 8'h0C;
                        img_next[1*8 +: 8]  = 8'h90;
                        img_next[2*8 +: 8]  = 8'h48;
                        img_next[6*8 +: 8]  = 8'h04;
                        img_next[9*8 +: 8]  = 8'h10;
                        img_next[10*8 +: 8] = 8'h49;
                    end
                    else
                    begin
                        if (v[15])
                        begin
                            img_next[8*8 + 2] = 1'b1;
                        end
                        mag_next = absv[14:0];
                    end
                end
                sdie_pkg::REQ_SYMBOL:
                begin
                    img_next[16*8 + 5] = value[5];
                    img_next[16*8 + 6] = value[6];
                    img_next[14*8 + 2] = value[7];
                end
                sdie_pkg::REQ_SMILEY:
                begin
                    img_next[3*8 +: 8] = 8'h00;
                    img_next[4*8 +: 8] = 8'h00;
                    img_next[5*8 +: 8] = img_reg[5*8 +: 8] & 8'h01;
                    case (value[2:0])
                        3'd1:
                        begin
                            img_next[3*8 + 2] = 1'b1;
                            img_next[4*8 +: 8] = 8'h10;
                        end
                        3'd2:
                        begin
                            img_next[4*8 +: 8] = 8'h12;
                            img_next[5*8 + 6] = 1'b1;
                        end
                        3'd3:
                        begin
                            img_next[4*8 +: 8] = 8'h82;
                            img_next[5*8 + 6] = 1'b1;
                        end
                        3'd4:
                        begin
                            img_next[3*8 + 2] = 1'b1;
                            img_next[4*8 +: 8] = 8'h02;
                            img_next[5*8 + 6] = 1'b1;
                        end
                        3'd5:
                        begin
                            img_next[3*8 + 2] = 1'b1;
                            img_next[4*8 +: 8] = 8'h02;
                        end
                        3'd6:
                        begin
                            img_next[4*8 +: 8] = 8'h80;
                            img_next[5*8 + 6] = 1'b1;
                        end
                        3'd7:
                        begin
                            img_next[3*8 + 2] = 1'b1;
                            img_next[4*8 +: 8] = 8'h12;
                            img_next[5*8 + 6] = 1'b1;
                        end
                        default: ;
                    endcase
                end
                sdie_pkg::REQ_BATTERY: img_next[16*8 + 4] = (value != 16'sd0);
                sdie_pkg::REQ_BLE:     img_next[5*8]      = (value != 16'sd0);
                default: ;
            endcase
        end
        else if (cmd.round)
        begin
            mag_next = quo_reg + ((rem_reg > 15'd5) ? 15'd1 : 15'd0);
            if (quo_reg + ((rem_reg > 15'd5) ? 15'd1 : 15'd0) > 15'd999)
            begin
                img_next[12*8 + 3] = 1'b1;
            end
        end
        else if (cmd.draw)
        begin
            img_next = img_reg | paint;
        end
    end

    // Hold image, request and decode flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_reg       <= '0;
            req_reg       <= sdie_pkg::REQ_BIG;
            numeric_reg   <= 1'b0;
            point_off_reg <= 1'b0;
        end
        else
        begin
            img_reg <= img_next;
            if (cmd.load)
            begin
                req_reg       <= req_type;
                numeric_reg   <= ((req_type == sdie_pkg::REQ_BIG) &&
                                  value <= 16'sd19995 && value >= -16'sd995) ||
                                 ((req_type == sdie_pkg::REQ_SMALL) &&
                                  value <= 16'sd99 && value >= -16'sd9);
                point_off_reg <= (req_type == sdie_pkg::REQ_BIG) &&
                                 (value > 16'sd1995 || value < -16'sd95);
            end
        end
    end

    // Payload registers: magnitude, divider, digit peel, output image
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (cmd.div_step)
        begin
            quo_reg <= quo_w;
            rem_reg <= rem_w;
        end
        if (cmd.draw)
        begin
            rest_reg <= rest_q;
        end
        else
        begin
            rest_reg <= mag_next;
        end
        if (cmd.publish)
        begin
            out_reg <= img_reg[143:0];
        end
    end

    assign image_low  = out_reg[63:0];
    assign image_mid  = out_reg[127:64];
    assign image_high = out_reg[143:128];

endmodule

// ===== src/segment_display_image_encoder.sv =====
// Top level: segment image encoder for a thermometer display.
// Symbol, smiley, mark and unknown requests and out-of-range numbers go from decode
// straight to output; numbers are drawn digit by digit, big numbers without a point
// after a divide step and a rounding step. One request at a time: the next is taken the cycle
// after the result is registered; a result still waiting for out_ready holds the
// finished image back. Reset (rst_n low, asynchronous) blanks the image store, not out_reg.
module segment_display_image_encoder
#(
    parameter int IMAGE_BYTES = sdie_pkg::IMAGE_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [15:0] value,
    input  logic               percent_on,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        image_low,
    output logic [63:0]        image_mid,
    output logic [15:0]        image_high
);

    sdie_pkg::sdie_cmd_t  cmd;
    sdie_pkg::sdie_stat_t stat;

    sdie_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sdie_dpath #(.IMAGE_BYTES(IMAGE_BYTES)) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .value      (value),
        .percent_on (percent_on),
        .cmd        (cmd),
        .stat       (stat),
        .image_low  (image_low),
        .image_mid  (image_mid),
        .image_high (image_high)
    );

endmodule

// ===== src/sdie_checker.sv =====
// Port checker for the segment image encoder, bound to the top level.
module sdie_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] image_high
);

    // Hold output beat until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(image_high))
        else $error("output beat dropped or changed while stalled");

    // Byte 17 always reads blank
    a_byte17: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> image_high[15:8] == 8'h00)
        else $error("image byte 17 not blank");

    // No new beat accepted the cycle after one
    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // A result rises only out of a busy cycle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised while idle");

endmodule

bind segment_display_image_encoder sdie_checker u_sdie_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .image_high (image_high)
);
